[rtl/core/ookpw_pkg.sv]
// Shared types, register codes and phase-resolution functions of the OOK pulse-width sender.
package ookpw_pkg;

    // Register indexes on the configuration channel
    localparam logic [7:0] CFG_CODE_WORD     = 8'd0;
    localparam logic [7:0] CFG_CODE_LENGTH   = 8'd1;
    localparam logic [7:0] CFG_FRAME_REPEATS = 8'd2;
    localparam logic [7:0] CFG_LONG_TICKS    = 8'd3;
    localparam logic [7:0] CFG_SHORT_TICKS   = 8'd4;
    localparam logic [7:0] CFG_GAP_TICKS     = 8'd5;
    localparam logic [7:0] CFG_LOCKOUT_TICKS = 8'd6;

    // Register reset values
    localparam logic [31:0] RST_CODE_WORD     = 32'd0;
    localparam logic [5:0]  RST_CODE_LENGTH   = 6'd24;
    localparam logic [7:0]  RST_FRAME_REPEATS = 8'd1;
    localparam logic [15:0] RST_LONG_TICKS    = 16'd0;
    localparam logic [15:0] RST_SHORT_TICKS   = 16'd0;
    localparam logic [23:0] RST_GAP_TICKS     = 24'd0;
    localparam logic [23:0] RST_LOCKOUT_TICKS = 24'd10000000;

    localparam logic [5:0]  MAX_CODE_LENGTH   = 6'd32;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HIGH = 3'd1,
        PH_LOW  = 3'd2,
        PH_GAP  = 3'd3,
        PH_LOCK = 3'd4
    } t_phase;

    // Point in the frame sequence from which the next non-empty phase is sought
    typedef enum logic [1:0] {
        ENT_BIT       = 2'd0,  // high phase of bit p
        ENT_LOW       = 2'd1,  // low phase of bit p
        ENT_FRAME_END = 2'd2,  // gap of frame f just finished
        ENT_LOCK      = 2'd3   // lockout
    } t_entry;

    typedef struct packed {
        logic [31:0] code_word;
        logic [5:0]  code_length;
        logic [7:0]  frame_repeats;
        logic [15:0] long_ticks;
        logic [15:0] short_ticks;
        logic [23:0] gap_ticks;
        logic [23:0] lockout_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [23:0] ticks_left;
        logic [5:0]  bit_pos;
        logic [7:0]  frames_sent;
    } t_state;

    typedef struct packed {
        logic line_level;
        logic busy;
    } t_result;

    function automatic logic [5:0] eff_len(t_cfg c);
        return (c.code_length > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH : c.code_length;
    endfunction

    function automatic logic code_bit(t_cfg c, logic [5:0] p);
        return p[5] ? 1'b0 : c.code_word[p[4:0]];
    endfunction

    function automatic logic [23:0] high_dur(t_cfg c, logic [5:0] p);
        return code_bit(c, p) ? {8'd0, c.long_ticks} : {8'd0, c.short_ticks};
    endfunction

    function automatic logic [23:0] low_dur(t_cfg c, logic [5:0] p);
        return code_bit(c, p) ? {8'd0, c.short_ticks} : {8'd0, c.long_ticks};
    endfunction

    // Find the first phase of nonzero duration from an entry point. With both
    // pulse lengths zero every bit is empty, so a frame reduces to its gap; with
    // either nonzero every bit has a nonzero phase, so the search is short.
    function automatic t_state settle(t_cfg c, t_entry e, logic [5:0] p, logic [7:0] f);
        t_state      r;
        logic [5:0]  len;
        logic [5:0]  pb;
        logic [7:0]  fn;
        logic        more;
        logic        frame_empty;
        logic        go_bit;
        logic        go_gap;
        logic        go_fend;
        logic        go_lock;
        len         = eff_len(c);
        fn          = f + 8'd1;
        more        = (fn < c.frame_repeats) && (fn != 8'd0);
        frame_empty = (len == 6'd0) || ((c.long_ticks == 16'd0) && (c.short_ticks == 16'd0));
        r           = '{phase: PH_IDLE, ticks_left: 24'd0, bit_pos: p, frames_sent: f};
        pb          = p;
        go_bit      = 1'b0;
        go_gap      = 1'b0;
        go_fend     = 1'b0;
        go_lock     = 1'b0;
        unique case (e)
            ENT_LOW: begin
                if (low_dur(c, p) != 24'd0) begin
                    r.phase      = PH_LOW;
                    r.ticks_left = low_dur(c, p);
                end else begin
                    go_bit = 1'b1;
                    pb     = p + 6'd1;
                end
            end
            ENT_BIT:       go_bit  = 1'b1;
            ENT_FRAME_END: go_fend = 1'b1;
            ENT_LOCK:      go_lock = 1'b1;
            default:       go_lock = 1'b1;
        endcase
        if (go_bit) begin
            r.bit_pos = pb;
            if (pb >= len) begin
                go_gap = 1'b1;
            end else if (high_dur(c, pb) != 24'd0) begin
                r.phase      = PH_HIGH;
                r.ticks_left = high_dur(c, pb);
            end else if (low_dur(c, pb) != 24'd0) begin
                r.phase      = PH_LOW;
                r.ticks_left = low_dur(c, pb);
            end else begin
                go_gap = 1'b1;
            end
        end
        if (go_gap) begin
            if (c.gap_ticks != 24'd0) begin
                r.phase      = PH_GAP;
                r.ticks_left = c.gap_ticks;
            end else begin
                go_fend = 1'b1;
            end
        end
        if (go_fend) begin
            if (more && !frame_empty) begin
                r.bit_pos     = 6'd0;
                r.frames_sent = fn;
                if (high_dur(c, 6'd0) != 24'd0) begin
                    r.phase      = PH_HIGH;
                    r.ticks_left = high_dur(c, 6'd0);
                end else begin
                    r.phase      = PH_LOW;
                    r.ticks_left = low_dur(c, 6'd0);
                end
            end else if (more && (c.gap_ticks != 24'd0)) begin
                r.bit_pos     = 6'd0;
                r.frames_sent = fn;
                r.phase       = PH_GAP;
                r.ticks_left  = c.gap_ticks;
            end else begin
                go_lock = 1'b1;
            end
        end
        if (go_lock) begin
            if (c.lockout_ticks != 24'd0) begin
                r.phase      = PH_LOCK;
                r.ticks_left = c.lockout_ticks;
            end else begin
                r.phase      = PH_IDLE;
                r.ticks_left = 24'd0;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/ookpw_cfg.sv]
// Configuration register file of the OOK pulse-width sender.
module ookpw_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [7:0]        i_index,
    input  logic [31:0]       i_data,
    output ookpw_pkg::t_cfg   o_cfg
);

    ookpw_pkg::t_cfg r_cfg;

    // Drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_word     <= ookpw_pkg::RST_CODE_WORD;
            r_cfg.code_length   <= ookpw_pkg::RST_CODE_LENGTH;
            r_cfg.frame_repeats <= ookpw_pkg::RST_FRAME_REPEATS;
            r_cfg.long_ticks    <= ookpw_pkg::RST_LONG_TICKS;
            r_cfg.short_ticks   <= ookpw_pkg::RST_SHORT_TICKS;
            r_cfg.gap_ticks     <= ookpw_pkg::RST_GAP_TICKS;
            r_cfg.lockout_ticks <= ookpw_pkg::RST_LOCKOUT_TICKS;
        end else if (i_wr) begin
            unique case (i_index)
                ookpw_pkg::CFG_CODE_WORD:     r_cfg.code_word     <= i_data;
                ookpw_pkg::CFG_CODE_LENGTH:   r_cfg.code_length   <= i_data[5:0];
                ookpw_pkg::CFG_FRAME_REPEATS: r_cfg.frame_repeats <= i_data[7:0];
                ookpw_pkg::CFG_LONG_TICKS:    r_cfg.long_ticks    <= i_data[15:0];
                ookpw_pkg::CFG_SHORT_TICKS:   r_cfg.short_ticks   <= i_data[15:0];
                ookpw_pkg::CFG_GAP_TICKS:     r_cfg.gap_ticks     <= i_data[23:0];
                ookpw_pkg::CFG_LOCKOUT_TICKS: r_cfg.lockout_ticks <= i_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/ookpw_core.sv]
// Phase sequencer of the OOK pulse-width sender: one tick per step.
module ookpw_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_button,
    input  ookpw_pkg::t_cfg     i_cfg,
    output ookpw_pkg::t_result  o_result
);

    ookpw_pkg::t_state r_st;
    ookpw_pkg::t_state n_st;
    ookpw_pkg::t_state start_st;
    ookpw_pkg::t_state cur_st;
    ookpw_pkg::t_state adv_st;
    ookpw_pkg::t_entry adv_entry;
    logic [5:0]        adv_pos;
    logic              starting;

    // First non-empty phase of a press
    assign start_st = ookpw_pkg::settle(i_cfg,
        (i_cfg.frame_repeats == 8'd0) ? ookpw_pkg::ENT_LOCK : ookpw_pkg::ENT_BIT,
        6'd0, 8'd0);

    assign starting = (r_st.phase == ookpw_pkg::PH_IDLE) && !i_button;

    // Phase that owns this tick
    always_comb begin
        if (starting) begin
            cur_st = start_st;
        end else begin
            cur_st = r_st;
        end
    end

    // Where to continue once the current phase runs out
    always_comb begin
        adv_entry = ookpw_pkg::ENT_LOCK;
        adv_pos   = cur_st.bit_pos;
        unique case (cur_st.phase)
            ookpw_pkg::PH_HIGH: adv_entry = ookpw_pkg::ENT_LOW;
            ookpw_pkg::PH_LOW: begin
                adv_entry = ookpw_pkg::ENT_BIT;
                adv_pos   = cur_st.bit_pos + 6'd1;
            end
            ookpw_pkg::PH_GAP: adv_entry = ookpw_pkg::ENT_FRAME_END;
            default:           adv_entry = ookpw_pkg::ENT_LOCK;
        endcase
    end

    assign adv_st = ookpw_pkg::settle(i_cfg, adv_entry, adv_pos, cur_st.frames_sent);

    always_comb begin
        n_st                = cur_st;
        o_result.line_level = (cur_st.phase == ookpw_pkg::PH_HIGH);
        o_result.busy       = (cur_st.phase != ookpw_pkg::PH_IDLE);
        if (cur_st.phase != ookpw_pkg::PH_IDLE) begin
            if (cur_st.ticks_left != 24'd1) begin
                n_st.ticks_left = cur_st.ticks_left - 24'd1;
            end else if (cur_st.phase == ookpw_pkg::PH_LOCK) begin
                n_st.phase      = ookpw_pkg::PH_IDLE;
                n_st.ticks_left = 24'd0;
            end else begin
                n_st = adv_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: ookpw_pkg::PH_IDLE, ticks_left: 24'd0,
                      bit_pos: 6'd0, frames_sent: 8'd0};
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    a_busy_has_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase != ookpw_pkg::PH_IDLE |-> r_st.ticks_left != 24'd0)
        else $error("active phase with no ticks left");

    a_idle_no_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == ookpw_pkg::PH_IDLE |-> r_st.ticks_left == 24'd0)
        else $error("idle with ticks pending");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_st))
        else $error("sequencer moved without a tick");

endmodule

[rtl/core/ook_pulse_width_code_sender.sv]
// Top level of the OOK pulse-width code sender: handshakes, tick register, result register.
//
//  Channel   Dir  Handshake                  Payload
//  i_s_*     in   i_s_tvalid / o_s_tready    tdata[0] button_level (0 = pressed)
//  o_m_*     out  o_m_tvalid / i_m_tready    tdata[0] line_level, tdata[1] busy_res
//  i_cfg_*   in   i_cfg_valid / o_cfg_ready  i_cfg_index register, i_cfg_data value
//
// One request is one tick; a new tick is taken every cycle while no result stalls;
// its result passes the tick register, then the result register, before it is offered.
// The phase sequencer settles all zero-length phases within the same cycle.
// Reset (i_rst_n low, synchronous) clears the handshake state, returns the
// sequencer to idle and loads the register defaults.
// A stalled result holds in the output register; the tick register then
// holds the next request and o_s_tready drops until the result is taken.
module ook_pulse_width_code_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick requests
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] button_level, [7:1] zero
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    ookpw_pkg::t_cfg    cfg;
    ookpw_pkg::t_result result;

    logic               r_in_valid;
    logic               r_in_button;
    logic               r_out_valid;
    ookpw_pkg::t_result r_out;
    logic               step;

    // Registers are always writable; writes must be issued only while the sender is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    ookpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Advance one tick when a request is held and the result slot is free or draining
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Hold the button sample until its tick is processed
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_button <= i_s_tdata[0];
        end
    end

    ookpw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_button (r_in_button),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.busy, r_out.line_level};

    a_high_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1])
        else $error("line high while not busy");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("request taken with both stages full");

    a_hold_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

[sim/ook_line_checker.sv]
// Result checker for the OOK pulse-width code sender: tracks requests, predicts line levels.
`timescale 1ns / 1ps

module ook_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] button_level, [7:1] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_model_idle
);

    ookpw_pkg::t_cfg     regs;
    ookpw_pkg::t_phase   ph;
    logic [23:0]         left;
    logic [5:0]          bitpos;
    logic [7:0]          frames;

    ookpw_pkg::t_result  levels_due[$];
    int                  mismatches;

    function automatic logic [5:0] bits_per_frame();
        return (regs.code_length > ookpw_pkg::MAX_CODE_LENGTH) ?
               ookpw_pkg::MAX_CODE_LENGTH : regs.code_length;
    endfunction

    // Positions 32 and up carry a zero bit
    function automatic logic bit_now();
        return bitpos[5] ? 1'b0 : regs.code_word[bitpos[4:0]];
    endfunction

    function automatic logic [23:0] mark_ticks();
        return bit_now() ? {8'd0, regs.long_ticks} : {8'd0, regs.short_ticks};
    endfunction

    function automatic logic [23:0] space_ticks();
        return bit_now() ? {8'd0, regs.short_ticks} : {8'd0, regs.long_ticks};
    endfunction

    function automatic void open_frame();
        bitpos = 6'd0;
        if (bits_per_frame() != 6'd0) begin
            ph   = ookpw_pkg::PH_HIGH;
            left = mark_ticks();
        end else begin
            ph   = ookpw_pkg::PH_GAP;
            left = regs.gap_ticks;
        end
    endfunction

    function automatic void open_lockout();
        ph   = ookpw_pkg::PH_LOCK;
        left = regs.lockout_ticks;
    endfunction

    function automatic void advance_phase();
        case (ph)
            ookpw_pkg::PH_HIGH: begin
                ph   = ookpw_pkg::PH_LOW;
                left = space_ticks();
            end
            ookpw_pkg::PH_LOW: begin
                bitpos = bitpos + 6'd1;
                if (bitpos < bits_per_frame()) begin
                    ph   = ookpw_pkg::PH_HIGH;
                    left = mark_ticks();
                end else begin
                    ph   = ookpw_pkg::PH_GAP;
                    left = regs.gap_ticks;
                end
            end
            ookpw_pkg::PH_GAP: begin
                frames = frames + 8'd1;
                if (frames < regs.frame_repeats && frames != 8'd0)
                    open_frame();
                else
                    open_lockout();
            end
            default: begin
                ph   = ookpw_pkg::PH_IDLE;
                left = 24'd0;
            end
        endcase
    endfunction

    // Zero-length phases take no tick
    function automatic void drop_empty_phases();
        while (ph != ookpw_pkg::PH_IDLE && left == 24'd0)
            advance_phase();
    endfunction

    // Line level and busy flag for one tick, moving the sequence on by that tick
    function automatic ookpw_pkg::t_result line_for_tick(logic pin);
        ookpw_pkg::t_result r;
        r.line_level = 1'b0;
        r.busy       = 1'b0;
        if (ph == ookpw_pkg::PH_IDLE) begin
            if (pin)
                return r;
            // the press tick is already the first tick of the first real phase
            frames = 8'd0;
            if (regs.frame_repeats != 8'd0)
                open_frame();
            else
                open_lockout();
            drop_empty_phases();
            if (ph == ookpw_pkg::PH_IDLE)
                return r;
        end
        r.line_level = (ph == ookpw_pkg::PH_HIGH);
        r.busy       = 1'b1;
        left         = left - 24'd1;
        drop_empty_phases();
        return r;
    endfunction

    function automatic void take_write(logic [7:0] idx, logic [31:0] val);
        case (idx)
            ookpw_pkg::CFG_CODE_WORD:     regs.code_word     = val;
            ookpw_pkg::CFG_CODE_LENGTH:   regs.code_length   = val[5:0];
            ookpw_pkg::CFG_FRAME_REPEATS: regs.frame_repeats = val[7:0];
            ookpw_pkg::CFG_LONG_TICKS:    regs.long_ticks    = val[15:0];
            ookpw_pkg::CFG_SHORT_TICKS:   regs.short_ticks   = val[15:0];
            ookpw_pkg::CFG_GAP_TICKS:     regs.gap_ticks     = val[23:0];
            ookpw_pkg::CFG_LOCKOUT_TICKS: regs.lockout_ticks = val[23:0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : track
        ookpw_pkg::t_result want;
        ookpw_pkg::t_result seen;
        if (!i_rst_n) begin
            regs.code_word     = ookpw_pkg::RST_CODE_WORD;
            regs.code_length   = ookpw_pkg::RST_CODE_LENGTH;
            regs.frame_repeats = ookpw_pkg::RST_FRAME_REPEATS;
            regs.long_ticks    = ookpw_pkg::RST_LONG_TICKS;
            regs.short_ticks   = ookpw_pkg::RST_SHORT_TICKS;
            regs.gap_ticks     = ookpw_pkg::RST_GAP_TICKS;
            regs.lockout_ticks = ookpw_pkg::RST_LOCKOUT_TICKS;
            ph         = ookpw_pkg::PH_IDLE;
            left       = 24'd0;
            bitpos     = 6'd0;
            frames     = 8'd0;
            mismatches = 0;
            levels_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.line_level = i_m_tdata[0];
                seen.busy       = i_m_tdata[1];
                if (levels_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual line %b busy %b",
                             $time, seen.line_level, seen.busy);
                end else begin
                    want = levels_due.pop_front();
                    if (seen !== want || i_m_tdata[7:2] !== 6'd0) begin
                        mismatches++;
                        $display("%0t ns: expected line %b busy %b, actual line %b busy %b pad %h",
                                 $time, want.line_level, want.busy,
                                 i_m_tdata[0], i_m_tdata[1], i_m_tdata[7:2]);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                take_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready)
                levels_due.push_back(line_for_tick(i_s_tdata[0]));
        end
        o_fail_count <= mismatches;
        o_pending    <= levels_due.size();
        o_model_idle <= (ph == ookpw_pkg::PH_IDLE);
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the OOK pulse-width code sender: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    // Register indexes past the end of the map; writes there must change nothing
    localparam logic [7:0] IDX_PAST_MAP  = 8'd7;
    localparam logic [7:0] IDX_TOP_OF_MAP = 8'hFF;

    // Quiet margin after the last result is taken, before registers are touched
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_TICKS  = 250;
    localparam int HOLD_CYCLES   = 64;

    typedef enum logic [1:0] {
        SINK_OPEN,  // always ready
        SINK_COIN,  // ready at random
        SINK_BEAT,  // ready on a regular beat pattern
        SINK_HOLD   // long hold-off, lets the block fill up
    } t_sink_mode;

    logic        clk;
    logic        rst_n;
    logic        tick_valid;
    logic        tick_ready;
    logic [7:0]  tick_data;
    logic        line_valid;
    logic        line_ready;
    logic [7:0]  line_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          pending;
    logic        model_idle;

    int          burst_left;
    bit          steady;
    int          random_count;

    ook_pulse_width_code_sender u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (tick_valid),
        .o_s_tready  (tick_ready),
        .i_s_tdata   (tick_data),
        .o_m_tvalid  (line_valid),
        .i_m_tready  (line_ready),
        .o_m_tdata   (line_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ook_line_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (tick_valid),
        .i_s_tready   (tick_ready),
        .i_s_tdata    (tick_data),
        .i_m_tvalid   (line_valid),
        .i_m_tready   (line_ready),
        .i_m_tdata    (line_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_model_idle (model_idle)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one tick request. Requests come in bursts of random length with
    // random gaps in between, unless a steady stretch is asked for.
    task automatic send_tick(input logic button);
        int gap;
        if (burst_left == 0) begin
            if (!steady) begin
                tick_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        tick_valid <= 1'b1;
        tick_data  <= {7'd0, button};
        do @(posedge clk); while (!tick_ready);
        burst_left--;
    endtask

    // Drop the request line and let one edge pass, so that the next
    // assignment to it falls in a later time step
    task automatic stop_ticks();
        tick_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Run out the current press with the button released, then wait until
    // every result is in and the block has had time to go quiet
    task automatic finish_press();
        stop_ticks();
        while (!model_idle)
            send_tick(1'b1);
        stop_ticks();
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] word, input logic [31:0] len,
                              input logic [31:0] reps, input logic [31:0] long_t,
                              input logic [31:0] short_t, input logic [31:0] gap_t,
                              input logic [31:0] lock_t);
        write_reg(ookpw_pkg::CFG_CODE_WORD,     word);
        write_reg(ookpw_pkg::CFG_CODE_LENGTH,   len);
        write_reg(ookpw_pkg::CFG_FRAME_REPEATS, reps);
        write_reg(ookpw_pkg::CFG_LONG_TICKS,    long_t);
        write_reg(ookpw_pkg::CFG_SHORT_TICKS,   short_t);
        write_reg(ookpw_pkg::CFG_GAP_TICKS,     gap_t);
        write_reg(ookpw_pkg::CFG_LOCKOUT_TICKS, lock_t);
    endtask

    // Short codes and durations keep a press to a few hundred ticks; the upper data
    // bits of every register but the code word carry junk that the register must discard
    task automatic random_setup();
        logic [31:0] junk;
        logic [5:0]  len;
        junk = $urandom;
        case ($urandom_range(0, 3))
            0:       len = 6'($urandom_range(0, 2));
            1, 2:    len = 6'($urandom_range(1, 8));
            default: len = 6'($urandom_range(9, 63));
        endcase
        set_config($urandom,
                   {junk[31:6], len},
                   {junk[31:8], 8'($urandom_range(0, 3))},
                   {junk[31:16], 16'($urandom_range(0, 3))},
                   {junk[31:16], 16'($urandom_range(0, 3))},
                   {junk[31:24], 24'($urandom_range(0, 4))},
                   {junk[31:24], 24'($urandom_range(0, 6))});
    endtask

    // Result sink: spans of differing readiness, with a long hold-off every
    // eighth span while the sender keeps offering requests
    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        int         spans;
        int         beat;
        line_ready <= 1'b0;
        spans = 0;
        beat  = 0;
        forever begin
            spans++;
            span = $urandom_range(16, 160);
            if (spans % 8 == 0)
                mode = SINK_HOLD;
            else
                mode = t_sink_mode'($urandom_range(0, 2));
            if (mode == SINK_HOLD) begin
                repeat (HOLD_CYCLES) begin
                    @(posedge clk);
                    line_ready <= 1'b0;
                end
            end else begin
                repeat (span) begin
                    @(posedge clk);
                    beat++;
                    case (mode)
                        SINK_OPEN: line_ready <= 1'b1;
                        SINK_COIN: line_ready <= 1'($urandom_range(0, 1));
                        default:   line_ready <= (beat % 3 != 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        rst_n      <= 1'b0;
        tick_valid <= 1'b0;
        tick_data  <= 8'd0;
        cfg_valid  <= 1'b0;
        cfg_index  <= ookpw_pkg::CFG_CODE_WORD;
        cfg_data   <= 32'd0;
        burst_left = 0;
        steady     = 1'b0;
        random_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle result with the register defaults; never press here, as the
        // default lockout is ten million ticks
        repeat (3) send_tick(1'b1);
        finish_press();

        // Largest gap and lockout, written but left unused
        set_config(32'h0, 32'd24, 32'd1, 32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        repeat (2) send_tick(1'b1);
        finish_press();
        write_reg(IDX_PAST_MAP, 32'hFFFFFFFF);
        write_reg(IDX_TOP_OF_MAP, 32'hFFFFFFFF);

        // Every phase zero: the press completes on its own tick
        set_config(32'h0, 32'd24, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        finish_press();

        // No frames: straight into lockout; presses during lockout are ignored
        set_config(32'h0, 32'd5, 32'd0, 32'd2, 32'd2, 32'hFFFFFF, 32'd3);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        finish_press();

        // No code bits: each frame is its gap alone; widest pulses unused
        set_config(32'hFFFFFFFF, 32'd0, 32'd3, 32'hFFFF, 32'hFFFF, 32'd1, 32'd1);
        send_tick(1'b0);
        finish_press();

        // Length above 32 saturates; all ones with only the long high phase
        set_config(32'hFFFFFFFF, 32'd63, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1);
        send_tick(1'b0);
        finish_press();

        // All zeros with only the long low phase, two frames
        set_config(32'h0, 32'd33, 32'd2, 32'd1, 32'd0, 32'd1, 32'd1);
        send_tick(1'b0);
        finish_press();

        // Most repeats with empty frames: all frames vanish, one lockout tick
        set_config(32'hA5A5A5A5, 32'd32, 32'd255, 32'd0, 32'd0, 32'd0, 32'd1);
        send_tick(1'b0);
        finish_press();

        // Plain press, mixed bits, every phase present
        set_config(32'h5, 32'd3, 32'd2, 32'd2, 32'd1, 32'd2, 32'd2);
        send_tick(1'b1);
        send_tick(1'b0);
        finish_press();

        // Long high pulse; hold the request line steady
        set_config(32'h1, 32'd1, 32'd1, 32'd40, 32'd1, 32'd1, 32'd1);
        steady = 1'b1;
        send_tick(1'b0);
        finish_press();
        steady = 1'b0;

        // Random settings, mostly well-formed presses with random button noise
        while (random_count < RANDOM_TICKS) begin
            random_setup();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(30, 80)) begin
                send_tick($urandom_range(0, 3) != 0);
                random_count++;
            end
            finish_press();
            steady = 1'b0;
        end

        finish_press();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ook_pulse_width_code_sender regression: pass");
        else
            $display("ook_pulse_width_code_sender regression: fail");
        $finish;
    end

    // Watchdog: several times the slowest run
    initial begin : watchdog
        #60_000_000;
        $display("ook_pulse_width_code_sender regression: fail");
        $finish;
    end

endmodule
